// File: sv/iscl_pkg.sv
// Package for the I2C SCL divider calculator: field widths, protocol limits,
// the divider result struct and the rounded-up shift helper.
// No dependencies.
`default_nettype none

package iscl_pkg;

	// field widths
	localparam int MCK_W = 29;
	localparam int REQ_W = 20;
	localparam int EXP_W = 3;
	localparam int DIV_W = 8;

	// ceil(mck / req) plus the floor step needs one more bit than mck
	localparam int PER_W = MCK_W + 1;
	// ceil(mck / 768000) stays below 2^10 for any 29-bit master clock
	localparam int LC_W = 10;
	// shift amount wide enough for exponent + 1
	localparam int SH_W = EXP_W + 1;

	localparam int EXP_MAX = 7;
	localparam int NUM_EXP = EXP_MAX + 1;

	localparam logic [MCK_W-1:0] MCK_RESET          = MCK_W'(120000000);
	localparam logic [REQ_W-1:0] LOW_TIME_LIMIT_HZ  = REQ_W'(384000);
	localparam logic [REQ_W-1:0] FAST_MODE_MAX_HZ   = REQ_W'(400000);
	// two low half periods at the low time limit
	localparam logic [REQ_W-1:0] LOW_TIME_DIVISOR   = REQ_W'(768000);
	localparam logic [PER_W-1:0] DIV_MAX            = PER_W'(255);
	localparam logic [PER_W-1:0] PERIOD_OVERHEAD    = PER_W'(8);
	localparam logic [LC_W-1:0]  HALF_OVERHEAD      = LC_W'(4);

	// 768000 = 375 * 2^11: drop the low 11 bits, divide the rest by 375
	localparam int LC_SHIFT    = 11;
	localparam int LCX_W       = MCK_W - LC_SHIFT;
	localparam int LC_RECIP_W  = 19;
	localparam int LC_RECIP_SH = 27;
	localparam int LCP_W       = LCX_W + LC_RECIP_W;
	localparam logic [LCX_W-1:0]      LC_ODD_DIVISOR = LCX_W'(375);
	// ceil(2^27 / 375); exact floor quotient for any 18-bit dividend
	localparam logic [LC_RECIP_W-1:0] LC_RECIP       = LC_RECIP_W'(357914);

	// divider pipeline result handed to the post stages
	typedef struct packed {
		logic             valid;
		logic [REQ_W-1:0] req;
		logic [MCK_W-1:0] quo;
		logic             rem_nz;
		logic [LC_W-1:0]  lc_quo;
		logic             lc_rem_nz;
	} iscl_div_res_t;

	// ceil(x / 2^sh)
	function automatic logic [PER_W-1:0] ceil_shr(input logic [PER_W-1:0] x,
			input logic [SH_W-1:0] sh);
		logic [PER_W-1:0] mask;
		mask = ~({PER_W{1'b1}} << sh);
		ceil_shr = (x >> sh) + PER_W'(|(x & mask));
	endfunction

endpackage

`default_nettype wire

// File: sv/iscl_div_pipe.sv
// Pipelined restoring divider for master clock / requested rate, one quotient
// bit per stage, with the low-time count (master clock / 768000) alongside.
// Depends on iscl_pkg.
`default_nettype none

module iscl_div_pipe
	import iscl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [REQ_W-1:0] in_req,
	input  wire logic [MCK_W-1:0] in_mck,
	output iscl_div_res_t         res
);

	// low-time count is final after this many stages
	localparam int LC_READY = 3;

	// stage k holds the state after k quotient bits
	logic             valid_s [0:MCK_W];
	logic [REQ_W-1:0] req_s   [0:MCK_W];
	logic [MCK_W-1:0] num_s   [0:MCK_W];
	logic [REQ_W-1:0] rem_a_s [0:MCK_W];
	logic [MCK_W-1:0] quo_a_s [0:MCK_W];

	logic [LCX_W-1:0] lcx_s1;
	logic [LCP_W-1:0] lcp_s1;
	logic             lcl_nz_s1;
	logic [LCX_W-1:0] lcx_s2;
	logic [LC_W-1:0]  lcq_s2;
	logic             lcl_nz_s2;
	logic [LC_W-1:0]  lc_quo_s    [LC_READY:MCK_W];
	logic             lc_rem_nz_s [LC_READY:MCK_W];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		req_s[0]   <= in_req;
		num_s[0]   <= in_mck;
		rem_a_s[0] <= '0;
		quo_a_s[0] <= '0;
	end

	// one trial subtract per stage
	for (genvar k = 0; k < MCK_W; k++) begin : g_stage
		logic [REQ_W:0] trial_a;
		logic           ge_a;

		assign trial_a = {rem_a_s[k], num_s[k][MCK_W-1]};
		assign ge_a    = trial_a >= {1'b0, req_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			req_s[k+1]   <= req_s[k];
			num_s[k+1]   <= num_s[k] << 1;
			quo_a_s[k+1] <= {quo_a_s[k][MCK_W-2:0], ge_a};
			rem_a_s[k+1] <= ge_a ? REQ_W'(trial_a - {1'b0, req_s[k]}) : trial_a[REQ_W-1:0];
		end
	end

	// low-time count: upper mck bits times the reciprocal of 375,
	// then a multiply-back check for a nonzero remainder
	always_ff @(posedge clk) begin
		lcx_s1    <= num_s[0][MCK_W-1:LC_SHIFT];
		lcp_s1    <= {{LC_RECIP_W{1'b0}}, num_s[0][MCK_W-1:LC_SHIFT]}
			* {{LCX_W{1'b0}}, LC_RECIP};
		lcl_nz_s1 <= |num_s[0][LC_SHIFT-1:0];
		lcx_s2    <= lcx_s1;
		lcq_s2    <= lcp_s1[LC_RECIP_SH +: LC_W];
		lcl_nz_s2 <= lcl_nz_s1;
		lc_quo_s[LC_READY]    <= lcq_s2;
		lc_rem_nz_s[LC_READY] <= lcl_nz_s2
			|| (lcx_s2 != {{(LCX_W-LC_W){1'b0}}, lcq_s2} * LC_ODD_DIVISOR);
	end

	// carry the count down to the divider output
	for (genvar k = LC_READY; k < MCK_W; k++) begin : g_lc_delay
		always_ff @(posedge clk) begin
			lc_quo_s[k+1]    <= lc_quo_s[k];
			lc_rem_nz_s[k+1] <= lc_rem_nz_s[k];
		end
	end

	// last stage out; remainder reduces to a round-up flag
	always_comb begin
		res.valid     = valid_s[MCK_W];
		res.req       = req_s[MCK_W];
		res.quo       = quo_a_s[MCK_W];
		res.rem_nz    = |rem_a_s[MCK_W];
		res.lc_quo    = lc_quo_s[MCK_W];
		res.lc_rem_nz = lc_rem_nz_s[MCK_W];
	end

endmodule

`default_nettype wire

// File: sv/iscl_post.sv
// Post stages: period rounding and floor, per-exponent divider lanes,
// smallest fitting exponent select and the registered result word.
// Depends on iscl_pkg.
`default_nettype none

module iscl_post
	import iscl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iscl_div_res_t     div,
	output logic [EXP_W-1:0]       prescale_exp,
	output logic [DIV_W-1:0]       low_divider,
	output logic [DIV_W-1:0]       high_divider,
	output logic                   bad_request,
	output logic                   done
);

	// stage 1: period, floor, low-time count
	logic [PER_W-1:0] period;
	logic [PER_W-1:0] period_fl;
	logic [LC_W-1:0]  lc;

	logic             valid_s1;
	logic [PER_W-1:0] diff_s1;
	logic [LC_W-1:0]  lcm4_s1;
	logic             fast_s1;
	logic             bad_s1;

	always_comb begin
		period    = PER_W'(div.quo) + PER_W'(div.rem_nz);
		period_fl = (period <= PERIOD_OVERHEAD) ? PERIOD_OVERHEAD + PER_W'(1) : period;
		lc        = div.lc_quo + LC_W'(div.lc_rem_nz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= div.valid;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= period_fl - PERIOD_OVERHEAD;
		lcm4_s1 <= (lc > HALF_OVERHEAD) ? lc - HALF_OVERHEAD : '0;
		fast_s1 <= div.req > LOW_TIME_LIMIT_HZ;
		bad_s1  <= (div.req == '0) || (div.req > FAST_MODE_MAX_HZ);
	end

	// stage 2: one lane per prescaler exponent
	logic [DIV_W-1:0] lane_lo  [NUM_EXP];
	logic [DIV_W-1:0] lane_hi  [NUM_EXP];
	logic             lane_fit [NUM_EXP];

	for (genvar e = 0; e < NUM_EXP; e++) begin : g_lane
		logic [PER_W-1:0] lo_fast;
		logic [PER_W-1:0] sum;
		logic [PER_W-1:0] hi_fast;
		logic [PER_W-1:0] lo_slow;
		logic [PER_W-1:0] lo;
		logic [PER_W-1:0] hi;

		assign lo_fast = ceil_shr(PER_W'(lcm4_s1), SH_W'(e));
		assign sum     = ceil_shr(diff_s1, SH_W'(e));
		assign hi_fast = (sum > lo_fast) ? sum - lo_fast : '0;
		// even split: ceil(diff / 2^(e+1))
		assign lo_slow = ceil_shr(diff_s1, SH_W'(e + 1));
		assign lo      = fast_s1 ? lo_fast : lo_slow;
		assign hi      = fast_s1 ? hi_fast : lo_slow;

		assign lane_lo[e]  = lo[DIV_W-1:0];
		assign lane_hi[e]  = hi[DIV_W-1:0];
		assign lane_fit[e] = (lo <= DIV_MAX) && (hi <= DIV_MAX);
	end

	logic             valid_s2;
	logic             bad_s2;
	logic [DIV_W-1:0] lo_s2  [NUM_EXP];
	logic [DIV_W-1:0] hi_s2  [NUM_EXP];
	logic             fit_s2 [NUM_EXP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		bad_s2 <= bad_s1;
		for (int e = 0; e < NUM_EXP; e++) begin
			lo_s2[e]  <= lane_lo[e];
			hi_s2[e]  <= lane_hi[e];
			fit_s2[e] <= lane_fit[e];
		end
	end

	// stage 3: smallest fitting exponent wins
	logic [EXP_W-1:0] sel_exp;
	logic [DIV_W-1:0] sel_lo;
	logic [DIV_W-1:0] sel_hi;
	logic             found;
	logic             bad;

	always_comb begin
		sel_exp = '0;
		sel_lo  = '0;
		sel_hi  = '0;
		found   = 1'b0;
		for (int e = NUM_EXP - 1; e >= 0; e--) begin
			if (fit_s2[e]) begin
				sel_exp = EXP_W'(e);
				sel_lo  = lo_s2[e];
				sel_hi  = hi_s2[e];
				found   = 1'b1;
			end
		end
		bad = bad_s2 || !found;
	end

	logic             valid_s3;
	logic [EXP_W-1:0] exp_s3;
	logic [DIV_W-1:0] lo_s3;
	logic [DIV_W-1:0] hi_s3;
	logic             bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// rejected requests report zero fields
	always_ff @(posedge clk) begin
		exp_s3 <= bad ? '0 : sel_exp;
		lo_s3  <= bad ? '0 : sel_lo;
		hi_s3  <= bad ? '0 : sel_hi;
		bad_s3 <= bad;
	end

	assign prescale_exp = exp_s3;
	assign low_divider  = lo_s3;
	assign high_divider = hi_s3;
	assign bad_request  = bad_s3;
	assign done         = valid_s3;

endmodule

`default_nettype wire

// File: sv/i2c_scl_divider_calc.sv
// Top level of the I2C SCL divider calculator: master clock register,
// divider pipeline and post stages. Depends on iscl_pkg, iscl_div_pipe, iscl_post.
//
// Usage:
//   Request channel: a word (requested_hz) is taken at each rising edge with
//   start high and busy low. busy is always low, so a request may enter on
//   every cycle; throughput is one word per cycle.
//   Result channel: done is high for exactly one cycle with prescale_exp,
//   low_divider, high_divider and bad_request. The result passes through one
//   entry stage, 29 divider stages of one quotient bit each and three post
//   stages, and is taken at the edge that ends the cycle in which done is high.
//   Results come back in request order. The receiver cannot hold them off;
//   nothing in the pipeline ever stalls.
//   Configuration: cfg_wr_en with cfg_wr_data writes the master clock in Hz.
//   Write it only with no request in flight; each request samples it on entry.
//   Reset: arst_n clears all valid flags and loads 120 MHz as master clock.
//   Rejected requests (zero, above 400 kHz, no fitting exponent) report
//   bad_request high and zero fields.
`default_nettype none

module i2c_scl_divider_calc
	import iscl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [REQ_W-1:0] requested_hz,
	input  wire logic             cfg_wr_en,
	input  wire logic [MCK_W-1:0] cfg_wr_data,
	output logic [EXP_W-1:0]      prescale_exp,
	output logic [DIV_W-1:0]      low_divider,
	output logic [DIV_W-1:0]      high_divider,
	output logic                  bad_request,
	output logic                  done
);

	logic [MCK_W-1:0] master_clock_q;
	logic             accept;
	iscl_div_res_t    div_res;

	// master clock register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_clock_q <= MCK_RESET;
		end else if (cfg_wr_en) begin
			master_clock_q <= cfg_wr_data;
		end
	end

	// fully pipelined: never busy
	assign busy   = 1'b0;
	assign accept = start && !busy;

	iscl_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_req   (requested_hz),
		.in_mck   (master_clock_q),
		.res      (div_res)
	);

	iscl_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.div          (div_res),
		.prescale_exp (prescale_exp),
		.low_divider  (low_divider),
		.high_divider (high_divider),
		.bad_request  (bad_request),
		.done         (done)
	);

endmodule

`default_nettype wire

// File: test/tb_i2c_scl_divider_calc.sv
// Testbench for i2c_scl_divider_calc: random and corner-case SCL requests under
// several master clock settings, each result checked against an in-bench model.
// Depends on iscl_pkg and the i2c_scl_divider_calc RTL.

module tb_i2c_scl_divider_calc;
	import iscl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	// pipeline length plus margin
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 125;

	typedef struct packed {
		logic [EXP_W-1:0] prescale;
		logic [DIV_W-1:0] lo_div;
		logic [DIV_W-1:0] hi_div;
		logic             bad;
	} scl_setting_t;

	// Predicts divider settings and matches them against returned words
	class setting_checker;
		scl_setting_t     owed_settings[$];
		logic [MCK_W-1:0] mck_hz;
		int               errors;
		int               accepted;
		int               rejected;
		int               matched;

		function new();
			mck_hz = MCK_RESET;
			errors = 0;
			accepted = 0;
			rejected = 0;
			matched = 0;
		endfunction

		function void set_clock(logic [MCK_W-1:0] hz);
			mck_hz = hz;
		endfunction

		function int pending();
			return owed_settings.size();
		endfunction

		function longint unsigned up_div(longint unsigned num, longint unsigned den);
			return (num + den - 1) / den;
		endfunction

		// smallest prescaler exponent whose dividers both fit a byte
		function scl_setting_t calc_setting(logic [REQ_W-1:0] req);
			scl_setting_t     s;
			longint unsigned  period;
			longint unsigned  low_ticks;
			longint unsigned  span;
			longint unsigned  scale;
			longint unsigned  lo;
			longint unsigned  hi;
			s = '{prescale: '0, lo_div: '0, hi_div: '0, bad: 1'b1};
			if (req == 0 || req > FAST_MODE_MAX_HZ)
				return s;
			period = up_div(mck_hz, req);
			if (period <= PERIOD_OVERHEAD)
				period = PERIOD_OVERHEAD + 1;
			low_ticks = up_div(mck_hz, LOW_TIME_DIVISOR);
			for (int e = 0; e <= EXP_MAX; e++) begin
				scale = 64'd1 << e;
				span = period - PERIOD_OVERHEAD;
				if (req > LOW_TIME_LIMIT_HZ) begin
					// low half held at the minimum low time, high gets the rest
					lo = (low_ticks > HALF_OVERHEAD) ?
						up_div(low_ticks - HALF_OVERHEAD, scale) : 0;
					hi = (up_div(span, scale) > lo) ? up_div(span, scale) - lo : 0;
				end else begin
					lo = up_div(span, 2 * scale);
					hi = lo;
				end
				if (lo <= DIV_MAX && hi <= DIV_MAX) begin
					s.prescale = EXP_W'(e);
					s.lo_div = DIV_W'(lo);
					s.hi_div = DIV_W'(hi);
					s.bad = 1'b0;
					return s;
				end
			end
			return s;
		endfunction

		function void note_request(logic [REQ_W-1:0] req);
			scl_setting_t s;
			s = calc_setting(req);
			accepted++;
			if (s.bad)
				rejected++;
			owed_settings.push_back(s);
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_setting(scl_setting_t got);
			scl_setting_t want;
			if (owed_settings.size() == 0) begin
				report($sformatf("unexpected word exp=%0d lo=%0d hi=%0d bad=%0b",
					got.prescale, got.lo_div, got.hi_div, got.bad));
				return;
			end
			want = owed_settings.pop_front();
			if (got.prescale !== want.prescale)
				report($sformatf("prescale_exp got %0d want %0d", got.prescale, want.prescale));
			if (got.lo_div !== want.lo_div)
				report($sformatf("low_divider got %0d want %0d", got.lo_div, want.lo_div));
			if (got.hi_div !== want.hi_div)
				report($sformatf("high_divider got %0d want %0d", got.hi_div, want.hi_div));
			if (got.bad !== want.bad)
				report($sformatf("bad_request got %0b want %0b", got.bad, want.bad));
			matched++;
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [REQ_W-1:0] requested_hz;
	logic             cfg_wr_en;
	logic [MCK_W-1:0] cfg_wr_data;
	logic [EXP_W-1:0] prescale_exp;
	logic [DIV_W-1:0] low_divider;
	logic [DIV_W-1:0] high_divider;
	logic             bad_request;
	logic             done;

	setting_checker chk = new();
	int             cycles = 0;
	int             clock_settings = 1;

	i2c_scl_divider_calc DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.requested_hz (requested_hz),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.prescale_exp (prescale_exp),
		.low_divider  (low_divider),
		.high_divider (high_divider),
		.bad_request  (bad_request),
		.done         (done)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycles, chk.pending());
			$display("FAILURE");
			$finish;
		end
	end

	// result monitor: every done pulse is one word
	always @(posedge clk) begin
		if (arst_n && done)
			chk.check_setting('{prescale: prescale_exp, lo_div: low_divider,
				hi_div: high_divider, bad: bad_request});
	end

	// present one request and hold it until taken
	task send_request(logic [REQ_W-1:0] req);
		@(negedge clk);
		start <= 1'b1;
		requested_hz <= req;
		do
			@(posedge clk);
		while (busy);
		chk.note_request(req);
	endtask

	// idle with junk on the request bus
	task idle_cycles(int n);
		for (int i = 0; i < n; i++) begin
			@(negedge clk);
			start <= 1'b0;
			requested_hz <= REQ_W'($urandom);
		end
	endtask

	task drain();
		while (chk.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// reconfigure only with the pipeline empty
	task write_clock(logic [MCK_W-1:0] hz);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hz;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= MCK_W'($urandom);
		chk.set_clock(hz);
		clock_settings++;
	endtask

	// weighted toward the rate and error boundaries
	function automatic logic [REQ_W-1:0] pick_request();
		logic [REQ_W-1:0] edges[10] = '{0, 1, 383999, 384000, 384001,
			399999, 400000, 400001, 1048575, 100000};
		case ($urandom_range(0, 9))
			0: return REQ_W'($urandom);
			1: return edges[$urandom_range(0, 9)];
			2, 3: return REQ_W'($urandom_range(370000, 400010));
			4, 5: return REQ_W'($urandom_range(1, 20000));
			default: return REQ_W'($urandom_range(1, 400000));
		endcase
	endfunction

	// random traffic in bursts with gaps of assorted length
	task random_phase(int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && sent < count; j++) begin
				send_request(pick_request());
				sent++;
			end
			case ($urandom_range(0, 3))
				0: ;
				1: idle_cycles($urandom_range(1, 3));
				2: idle_cycles($urandom_range(1, 12));
				default: idle_cycles($urandom_range(20, 40));
			endcase
		end
		idle_cycles(1);
	endtask

	initial begin
		static logic [REQ_W-1:0] corners[16] = '{0, 1, 2, 1000, 1838, 1839, 50000, 100000,
			383999, 384000, 384001, 399999, 400000, 400001, 524288, 1048575};
		logic [MCK_W-1:0] clocks[7];

		arst_n = 1'b0;
		start = 1'b0;
		requested_hz = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner requests at the reset clock, back to back
		foreach (corners[i])
			send_request(corners[i]);
		idle_cycles(1);
		random_phase(RANDOM_PER_PHASE);

		// range ends, the widest register value, zero, random, then reset value
		clocks = '{1000000, 300000000, {MCK_W{1'b1}}, 0,
			MCK_W'($urandom_range(1000000, 300000000)),
			MCK_W'($urandom_range(1000000, 300000000)), MCK_RESET};
		foreach (clocks[i]) begin
			write_clock(clocks[i]);
			random_phase(RANDOM_PER_PHASE);
		end

		drain();
		$display("Checked %0d requests (%0d rejected) across %0d master clock settings.",
			chk.accepted, chk.rejected, clock_settings);
		if (chk.errors == 0 && chk.pending() == 0 && chk.matched == chk.accepted) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", chk.errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
